// ===== src/cts_pkg.sv =====
// Shared definitions for the cosine Taylor series unit: sizes, fixed-point
// constants, sequencer states and the reciprocal table for the series divisors.
// No dependencies.
`default_nettype none

package cts_pkg;

   localparam int unsigned NUM_TERMS = 7;          // series terms, 1 to 10

   localparam int unsigned ANGLE_W   = 32;         // Q16.16 angle
   localparam int unsigned COS_W     = 32;         // Q2.30 cosine
   localparam int unsigned HP_W      = 19;         // half period register
   localparam int unsigned REM_W     = HP_W + 1;   // remainder below 2*half period
   localparam int unsigned DVD_W     = 32;         // reduction dividend, 2 bits/step
   localparam int unsigned CNT_W     = 4;
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W / 2 - 1);

   localparam int unsigned MUL_W     = 28;         // shared multiplier operand
   localparam int unsigned PP_W      = 2 * MUL_W;
   localparam int unsigned ACC_W     = PP_W + 2;
   localparam int unsigned MAG_W     = 42;         // |s|, clamped to 2^41
   localparam int unsigned Y_W       = 36;         // x^2 in Q30
   localparam int unsigned R_W       = 47;         // |s|*y >> 30
   localparam int unsigned RCP_W     = 56;         // ceil(2^56 / d)
   localparam int unsigned SUM_W     = R_W + 1;
   localparam int unsigned K_W       = $clog2(NUM_TERMS + 1);

   localparam logic [HP_W-1:0]  HP_RESET  = HP_W'(205881);
   localparam logic [MAG_W-1:0] Q30_ONE   = MAG_W'(1) << 30;
   localparam logic [MAG_W-1:0] ACC_LIMIT = MAG_W'(1) << 41;
   localparam logic [COS_W-1:0] COS_MAX   = {1'b0, {(COS_W-1){1'b1}}};
   localparam logic [COS_W-1:0] COS_MIN   = {1'b1, {(COS_W-1){1'b0}}};

   // partial product steps of one 4-product multiply
   localparam logic [2:0] PC_LO   = 3'd1;
   localparam logic [2:0] PC_MID0 = 3'd2;
   localparam logic [2:0] PC_MID1 = 3'd3;
   localparam logic [2:0] PC_HI   = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIX,
      ST_SQ,
      ST_SQW,
      ST_MULY,
      ST_MULR,
      ST_UPD,
      ST_OUT
   } state_type;

   // ceil(2^56 / ((2k-1)*2k)): exact floor division for dividends below 2^47
   function automatic logic [RCP_W-1:0] recip_factor(input logic [3:0] k);
      logic [RCP_W-1:0] v;
      case (k)
         4'd1:    v = 56'd36028797018963968;
         4'd2:    v = 56'd6004799503160662;
         4'd3:    v = 56'd2401919801264265;
         4'd4:    v = 56'd1286742750677285;
         4'd5:    v = 56'd800639933754755;
         4'd6:    v = 56'd545890863923697;
         4'd7:    v = 56'd395920846362242;
         4'd8:    v = 56'd300239975158034;
         4'd9:    v = 56'd235482333457281;
         4'd10:   v = 56'd189625247468232;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== src/cosine_taylor_series_unit.sv =====
// Cosine of a Q16.16 angle by range reduction and a nested Maclaurin series.
// One sequencer drives a 2-bit/cycle remainder unit and a shared 28x28 multiplier.
// Depends on cts_pkg.
//
//   channel   ports                          transfer
//   --------  -----------------------------  ------------------------------
//   request   start, busy, req_angle         rising edge with start & !busy
//   response  rsp_valid, rsp_cosine          one-cycle strobe, no back-pressure
//   csr       csr_wr_en, csr_half_period     rising edge with csr_wr_en
//
// busy stays high longer when |angle| exceeds a nonzero half period.
// The remainder of the range reduction retires the 32 dividend bits, 2 per cycle;
// each of the seven series steps takes four partial products for
// |s|*y and four for the reciprocal divide on the one multiplier, then update.
// Synchronous active-high reset clears the sequencer and the strobe and loads
// the half period reset value. rsp_valid rises in the cycle busy falls.
`default_nettype none

module cosine_taylor_series_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [cts_pkg::ANGLE_W-1:0]  req_angle,
   input  logic                                csr_wr_en,
   input  logic        [cts_pkg::HP_W-1:0]     csr_half_period,
   output logic                                rsp_valid,
   output logic signed [cts_pkg::COS_W-1:0]    rsp_cosine
);

   cts_pkg::state_type state_ff, state_in;

   logic [cts_pkg::HP_W-1:0]  hp_ff, hp_in;
   logic [cts_pkg::DVD_W-1:0] dvd_ff, dvd_in;
   logic [cts_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [cts_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [cts_pkg::HP_W-1:0]  mx_ff, mx_in;
   logic [cts_pkg::PP_W-1:0]  pp_ff, pp_in;
   logic [cts_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [cts_pkg::MUL_W-1:0] l1_ff, l1_in;
   logic [cts_pkg::Y_W-1:0]   y_ff, y_in;
   logic [cts_pkg::MAG_W-1:0] m_ff, m_in;
   logic                      neg_ff, neg_in;
   logic [cts_pkg::R_W-1:0]   r_ff, r_in;
   logic [cts_pkg::K_W-1:0]   k_ff, k_in;
   logic [2:0]                pc_ff, pc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [cts_pkg::COS_W-1:0] rsp_cosine_ff, rsp_cosine_in;

   logic                        accept;
   logic                        hp_zero;
   logic                        a_above, a_below;
   logic signed [cts_pkg::ANGLE_W:0] ang_x, hp_x, above_diff, below_diff, ang_abs;
   logic [cts_pkg::REM_W-1:0]   div_d;
   logic [cts_pkg::REM_W:0]     t1, t2, s1, s2;
   logic [cts_pkg::MUL_W-1:0]   op_a, op_b;
   logic [cts_pkg::RCP_W-1:0]   rcp;
   logic [cts_pkg::SUM_W-1:0]   q_w, one_w, mag_raw;
   logic                        neg_raw;
   logic [cts_pkg::COS_W:0]     neg_val;

   assign busy       = (state_ff != cts_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cosine = rsp_cosine_ff;

   assign hp_zero    = (hp_ff == '0);
   assign ang_x      = {req_angle[cts_pkg::ANGLE_W-1], req_angle};
   assign hp_x       = signed'({{(cts_pkg::ANGLE_W + 1 - cts_pkg::HP_W){1'b0}}, hp_ff});
   assign a_above    = ang_x > hp_x;
   assign a_below    = ang_x < -hp_x;
   assign above_diff = ang_x - hp_x;
   assign below_diff = -hp_x - ang_x;
   assign ang_abs    = ang_x[cts_pkg::ANGLE_W] ? -ang_x : ang_x;
   assign div_d      = {hp_ff, 1'b0};

   // two restoring remainder steps per cycle
   always_comb begin
      t1 = {rem_ff, dvd_ff[cts_pkg::DVD_W-1]};
      s1 = (t1 >= {1'b0, div_d}) ? t1 - {1'b0, div_d} : t1;
      t2 = {s1[cts_pkg::REM_W-1:0], dvd_ff[cts_pkg::DVD_W-2]};
      s2 = (t2 >= {1'b0, div_d}) ? t2 - {1'b0, div_d} : t2;
   end

   // shared multiplier operands
   assign rcp = cts_pkg::recip_factor(4'(k_ff));
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         cts_pkg::ST_SQ: begin
            op_a = cts_pkg::MUL_W'(mx_ff);
            op_b = cts_pkg::MUL_W'(mx_ff);
         end
         cts_pkg::ST_MULY: begin
            op_a = pc_ff[0] ? cts_pkg::MUL_W'(m_ff[cts_pkg::MAG_W-1:cts_pkg::MUL_W])
                            : m_ff[cts_pkg::MUL_W-1:0];
            op_b = pc_ff[1] ? cts_pkg::MUL_W'(y_ff[cts_pkg::Y_W-1:cts_pkg::MUL_W])
                            : y_ff[cts_pkg::MUL_W-1:0];
         end
         cts_pkg::ST_MULR: begin
            op_a = pc_ff[0] ? cts_pkg::MUL_W'(r_ff[cts_pkg::R_W-1:cts_pkg::MUL_W])
                            : r_ff[cts_pkg::MUL_W-1:0];
            op_b = pc_ff[1] ? rcp[cts_pkg::RCP_W-1:cts_pkg::MUL_W]
                            : rcp[cts_pkg::MUL_W-1:0];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // partial product accumulation, low-order bits retired as they settle
   always_comb begin
      acc_in = acc_ff;
      l1_in  = l1_ff;
      case (pc_ff)
         cts_pkg::PC_LO:   acc_in = cts_pkg::ACC_W'(pp_ff);
         cts_pkg::PC_MID0: acc_in = (acc_ff >> cts_pkg::MUL_W) + cts_pkg::ACC_W'(pp_ff);
         cts_pkg::PC_MID1: begin
            acc_in = acc_ff + cts_pkg::ACC_W'(pp_ff);
            l1_in  = acc_in[cts_pkg::MUL_W-1:0];
         end
         cts_pkg::PC_HI:   acc_in = (acc_ff >> cts_pkg::MUL_W) + cts_pkg::ACC_W'(pp_ff);
         default:          acc_in = acc_ff;
      endcase
   end

   // s = 1 - sign(s) * q, kept as sign and magnitude
   always_comb begin
      q_w   = cts_pkg::SUM_W'(r_ff);
      one_w = cts_pkg::SUM_W'(cts_pkg::Q30_ONE);
      if (neg_ff) begin
         mag_raw = one_w + q_w;
         neg_raw = 1'b0;
      end else if (q_w <= one_w) begin
         mag_raw = one_w - q_w;
         neg_raw = 1'b0;
      end else begin
         mag_raw = q_w - one_w;
         neg_raw = 1'b1;
      end
   end

   assign neg_val = '0 - m_ff[cts_pkg::COS_W:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cts_pkg::ST_IDLE: begin
            if (accept) begin
               if (hp_zero || !(a_above || a_below)) state_in = cts_pkg::ST_SQ;
               else state_in = cts_pkg::ST_DIV;
            end
         end
         cts_pkg::ST_DIV: begin
            if (cnt_ff == cts_pkg::DIV_LAST) state_in = cts_pkg::ST_FIX;
         end
         cts_pkg::ST_FIX:  state_in = cts_pkg::ST_SQ;
         cts_pkg::ST_SQ:   state_in = cts_pkg::ST_SQW;
         cts_pkg::ST_SQW:  state_in = cts_pkg::ST_MULY;
         cts_pkg::ST_MULY: begin
            if (pc_ff == cts_pkg::PC_HI) state_in = cts_pkg::ST_MULR;
         end
         cts_pkg::ST_MULR: begin
            if (pc_ff == cts_pkg::PC_HI) state_in = cts_pkg::ST_UPD;
         end
         cts_pkg::ST_UPD: begin
            if (k_ff == cts_pkg::K_W'(1)) state_in = cts_pkg::ST_OUT;
            else state_in = cts_pkg::ST_MULY;
         end
         cts_pkg::ST_OUT:  state_in = cts_pkg::ST_IDLE;
         default:          state_in = cts_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      hp_in         = csr_wr_en ? csr_half_period : hp_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      mx_in         = mx_ff;
      pp_in         = op_a * op_b;
      y_in          = y_ff;
      m_in          = m_ff;
      neg_in        = neg_ff;
      r_in          = r_ff;
      k_in          = k_ff;
      pc_in         = pc_ff;
      rsp_valid_in  = 1'b0;
      rsp_cosine_in = rsp_cosine_ff;
      case (state_ff)
         cts_pkg::ST_IDLE: begin
            cnt_in = '0;
            rem_in = '0;
            dvd_in = a_above ? above_diff[cts_pkg::DVD_W-1:0]
                             : below_diff[cts_pkg::DVD_W-1:0];
            mx_in  = hp_zero ? '0 : ang_abs[cts_pkg::HP_W-1:0];
         end
         cts_pkg::ST_DIV: begin
            rem_in = s2[cts_pkg::REM_W-1:0];
            dvd_in = dvd_ff << 2;
            cnt_in = cnt_ff + 1'b1;
         end
         cts_pkg::ST_FIX: begin
            // |x| = |rem - P| for both reduction directions
            mx_in = (rem_ff >= cts_pkg::REM_W'(hp_ff))
                  ? cts_pkg::HP_W'(rem_ff - cts_pkg::REM_W'(hp_ff))
                  : cts_pkg::HP_W'(cts_pkg::REM_W'(hp_ff) - rem_ff);
         end
         cts_pkg::ST_SQW: begin
            y_in   = pp_ff[cts_pkg::Y_W+1:2];
            m_in   = cts_pkg::Q30_ONE;
            neg_in = 1'b0;
            k_in   = cts_pkg::K_W'(cts_pkg::NUM_TERMS);
            pc_in  = '0;
         end
         cts_pkg::ST_MULY: begin
            if (pc_ff == cts_pkg::PC_HI) begin
               pc_in = '0;
               r_in  = {acc_in[cts_pkg::R_W-cts_pkg::MUL_W+1:0],
                        l1_ff[cts_pkg::MUL_W-1:2]};
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         cts_pkg::ST_MULR: begin
            if (pc_ff == cts_pkg::PC_HI) begin
               pc_in = '0;
               r_in  = acc_in[cts_pkg::R_W-1:0];
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         cts_pkg::ST_UPD: begin
            neg_in = neg_raw;
            m_in   = (mag_raw > cts_pkg::SUM_W'(cts_pkg::ACC_LIMIT))
                   ? cts_pkg::ACC_LIMIT : mag_raw[cts_pkg::MAG_W-1:0];
            k_in   = k_ff - 1'b1;
         end
         cts_pkg::ST_OUT: begin
            rsp_valid_in = 1'b1;
            if (!neg_ff) begin
               rsp_cosine_in = (m_ff > cts_pkg::MAG_W'(cts_pkg::COS_MAX))
                             ? cts_pkg::COS_MAX : m_ff[cts_pkg::COS_W-1:0];
            end else begin
               rsp_cosine_in = (m_ff > cts_pkg::MAG_W'(cts_pkg::COS_MIN))
                             ? cts_pkg::COS_MIN : neg_val[cts_pkg::COS_W-1:0];
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cts_pkg::ST_IDLE;
         hp_ff        <= cts_pkg::HP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hp_ff        <= hp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      mx_ff         <= mx_in;
      pp_ff         <= pp_in;
      acc_ff        <= acc_in;
      l1_ff         <= l1_in;
      y_ff          <= y_in;
      m_ff          <= m_in;
      neg_ff        <= neg_in;
      r_ff          <= r_in;
      k_ff          <= k_in;
      pc_ff         <= pc_in;
      rsp_cosine_ff <= rsp_cosine_in;
   end

endmodule

`default_nettype wire

// ===== src/cts_checker.sv =====
// Port-level checks for the cosine Taylor series unit, bound to its top level.
// Depends on cosine_taylor_series_unit.
`default_nettype none

module cts_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // an accepted request makes the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request transfer did not raise busy");

   // the result strobe never stays high in consecutive cycles
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a result only at the end of a busy period
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result strobe without a finished item");

   // finishing an item always delivers its result
   a_busy_end_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy fell without a result transfer");

endmodule

bind cosine_taylor_series_unit cts_checker u_cts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

`default_nettype wire
